// ===== hdl/lpr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Label partition refiner package
// Shared types and constants for the partition refiner controller, datapath
// and top level.
// ----------------------------------------------------------------------------
package lpr_pkg;

    localparam int STORE_DEPTH    = 64;
    localparam int ADDR_W         = 6;
    localparam int MASK_W         = 64;
    localparam int COUNT_W        = 7;
    localparam int NUM_STATES_DEF = 64;

    typedef struct packed {
        logic              req_type;
        logic [MASK_W-1:0] label_mask;
        logic [ADDR_W-1:0] block_index;
    } t_req;

    typedef struct packed {
        logic [COUNT_W-1:0] block_count;
        logic [MASK_W-1:0]  block_mask;
        logic               out_of_range;
    } t_rsp;

    typedef struct packed {
        logic              load;
        logic              rd_en;
        logic              rd_from_req;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_out;
        logic              wr_in;
        logic              rsp_refine;
        logic              rsp_read;
    } t_cmd;

    typedef struct packed {
        logic               split;
        logic [COUNT_W-1:0] count;
    } t_sts;

endpackage
`default_nettype wire

// ===== hdl/label_partition_refiner.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Label partition refiner
// Keeps a partition of up to NUM_STATES states as a store of block masks and
// splits every existing block against each label word.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low, and its result word
// appears on o_rsp for one cycle with o_strobe high, which cannot be held
// off. A read word reads its block from the store and registers the result
// word. A refine word walks the blocks that exist when it arrives through
// the block store, one block at a time; a block that splits takes a second
// state for its second store write. Busy drops in the cycle the result is
// shown, so the next word can start then. Entry 0 of the store reads as the
// full state mask until it is first written, so no clearing pass follows
// reset.
// ----------------------------------------------------------------------------
module label_partition_refiner #(
    parameter int NUM_STATES = lpr_pkg::NUM_STATES_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    input  wire lpr_pkg::t_req i_req,
    output logic               busy,
    output lpr_pkg::t_rsp      o_rsp,
    output logic               o_strobe
);
    import lpr_pkg::*;

    t_cmd cmd;
    t_sts sts;

    lpr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_read  (i_req.req_type),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    lpr_dp #(
        .NUM_STATES (NUM_STATES)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .o_rsp    (o_rsp),
        .o_strobe (o_strobe)
    );

`ifndef ASSERT_OFF
    a_take_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy did not rise after a word was taken");

    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result word without a word in progress");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_rsp.block_count != '0) &&
                     (o_rsp.block_count <= COUNT_W'(STORE_DEPTH)))
        else $error("block count out of range");

    a_oor_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_rsp.out_of_range) |-> (o_rsp.block_mask == '0))
        else $error("out of range read returned a nonzero mask");
`endif

endmodule
`default_nettype wire

// ===== hdl/lpr_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Partition refiner controller
// Sequences one word at a time: the walk over the existing blocks for a
// refine word, and the single store read for a read word.
// ----------------------------------------------------------------------------
module lpr_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic          i_read,
    input  wire lpr_pkg::t_sts i_sts,
    output lpr_pkg::t_cmd      o_cmd,
    output logic               o_busy
);
    import lpr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_WR2,
        S_FIN,
        S_RDOUT
    } t_state;

    t_state            r_state, n_state;
    logic [ADDR_W-1:0] r_idx, n_idx;
    logic [ADDR_W-1:0] r_last, n_last;
    logic              r_busy;

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_last  = r_last;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load  = 1'b1;
                    o_cmd.rd_en = 1'b1;
                    if (i_read) begin
                        o_cmd.rd_from_req = 1'b1;
                        n_state           = S_RDOUT;
                    end else begin
                        o_cmd.rd_addr = '0;
                        n_idx         = '0;
                        n_last        = ADDR_W'(i_sts.count - COUNT_W'(1));
                        n_state       = S_EVAL;
                    end
                end
            end
            S_EVAL: begin
                if (i_sts.split) begin
                    o_cmd.wr_out = 1'b1;
                    n_state      = S_WR2;
                end else if (r_idx == r_last) begin
                    n_state = S_FIN;
                end else begin
                    n_idx         = r_idx + ADDR_W'(1);
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_addr = n_idx;
                end
            end
            S_WR2: begin
                o_cmd.wr_in = 1'b1;
                if (r_idx == r_last) begin
                    n_state = S_FIN;
                end else begin
                    n_idx         = r_idx + ADDR_W'(1);
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_addr = n_idx;
                    n_state       = S_EVAL;
                end
            end
            S_FIN: begin
                o_cmd.rsp_refine = 1'b1;
                n_state          = S_IDLE;
            end
            S_RDOUT: begin
                o_cmd.rsp_read = 1'b1;
                n_state        = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
        end
        r_idx  <= n_idx;
        r_last <= n_last;
    end

    assign o_busy = r_busy;

endmodule
`default_nettype wire

// ===== hdl/lpr_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Partition refiner datapath
// Block store, block count, split test and the registered result word.
// ----------------------------------------------------------------------------
module lpr_dp #(
    parameter int NUM_STATES = lpr_pkg::NUM_STATES_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire lpr_pkg::t_req i_req,
    input  wire lpr_pkg::t_cmd i_cmd,
    output lpr_pkg::t_sts      o_sts,
    output lpr_pkg::t_rsp      o_rsp,
    output logic               o_strobe
);
    import lpr_pkg::*;

    localparam logic [MASK_W-1:0] StateMask = {MASK_W{1'b1}} >> (MASK_W - NUM_STATES);

    logic [MASK_W-1:0]  r_mem [STORE_DEPTH];
    logic [MASK_W-1:0]  r_mem_q;
    logic               r_rd_fix;
    logic [ADDR_W-1:0]  r_rd_addr;
    logic               r_e0_wr;
    logic [COUNT_W-1:0] r_count;
    logic [MASK_W-1:0]  r_label;
    logic [ADDR_W-1:0]  r_req_idx;
    t_rsp               r_rsp;
    logic               r_strobe;

    logic [ADDR_W-1:0]  rd_addr;
    logic [MASK_W-1:0]  blk;
    logic [MASK_W-1:0]  overlap;
    logic [MASK_W-1:0]  outside;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [MASK_W-1:0]  wr_data;
    logic               oor;

    // Entry 0 reads as the full state mask until it is first written.
    assign rd_addr = i_cmd.rd_from_req ? i_req.block_index : i_cmd.rd_addr;
    assign blk     = r_rd_fix ? StateMask : r_mem_q;
    assign overlap = blk & r_label;
    assign outside = blk & ~r_label;
    assign wr_en   = i_cmd.wr_out | i_cmd.wr_in;
    assign wr_addr = i_cmd.wr_out ? r_rd_addr : r_count[ADDR_W-1:0];
    assign wr_data = i_cmd.wr_out ? outside : overlap;
    assign oor     = ({1'b0, r_req_idx} >= r_count);

    assign o_sts.split = (overlap != '0) && (outside != '0) && !r_count[COUNT_W-1];
    assign o_sts.count = r_count;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_mem_q   <= r_mem[rd_addr];
            r_rd_addr <= rd_addr;
            r_rd_fix  <= (rd_addr == '0) && !r_e0_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= COUNT_W'(1);
            r_e0_wr  <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            if (i_cmd.wr_in) begin
                r_count <= r_count + COUNT_W'(1);
            end
            if (i_cmd.wr_out && (r_rd_addr == '0)) begin
                r_e0_wr <= 1'b1;
            end
            r_strobe <= i_cmd.rsp_refine | i_cmd.rsp_read;
        end
        if (i_cmd.load) begin
            r_label   <= i_req.label_mask & StateMask;
            r_req_idx <= i_req.block_index;
        end
        if (i_cmd.rsp_refine) begin
            r_rsp.block_count  <= r_count;
            r_rsp.block_mask   <= '0;
            r_rsp.out_of_range <= 1'b0;
        end else if (i_cmd.rsp_read) begin
            r_rsp.block_count  <= r_count;
            r_rsp.block_mask   <= oor ? '0 : blk;
            r_rsp.out_of_range <= oor;
        end
    end

    assign o_rsp    = r_rsp;
    assign o_strobe = r_strobe;

endmodule
`default_nettype wire

// ===== tb/lpr_tb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Label partition refiner testbench codes
// Request type codes shared by the stimulus side and the checker.
// ----------------------------------------------------------------------------
package lpr_tb_pkg;

    localparam logic REQ_REFINE = 1'b0;
    localparam logic REQ_READ   = 1'b1;

endpackage

// ===== tb/label_partition_refiner_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Label partition refiner checker
// Watches the request and result channels of the refiner, keeps its own copy
// of the partition, predicts the result word of every accepted request word
// and compares each strobed result word field by field with the oldest
// prediction. Counts failures and predictions still waiting for the top.
// ----------------------------------------------------------------------------
module label_partition_refiner_checker
    import lpr_pkg::*;
    import lpr_tb_pkg::*;
#(
    parameter int NUM_STATES = NUM_STATES_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    input  wire logic i_busy,
    input  t_req      i_req,
    input  t_rsp      i_rsp,
    input  wire logic i_strobe,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_result_count,
    output int        o_split_count
);

    localparam logic [MASK_W-1:0] STATE_SPAN = {MASK_W{1'b1}} >> (MASK_W - NUM_STATES);

    logic [MASK_W-1:0] part_block [STORE_DEPTH];
    int unsigned       part_size;
    t_rsp              awaited_rsp [$];
    int                fail_tally;
    int                result_tally;
    int                split_tally;

    // Splits every block that existed before the word against the label, or
    // looks up one block, and returns the result word that must follow.
    function automatic t_rsp apply_word(input t_req w);
        t_rsp              r;
        logic [MASK_W-1:0] label;
        logic [MASK_W-1:0] overlap;
        logic [MASK_W-1:0] rest;
        int unsigned       walk_end;
        r = '0;
        if (w.req_type == REQ_REFINE) begin
            label    = w.label_mask & STATE_SPAN;
            walk_end = part_size;
            for (int unsigned b = 0; b < walk_end; b++) begin
                overlap = part_block[b] & label;
                rest    = part_block[b] & ~label;
                if (overlap != '0 && rest != '0 && part_size < STORE_DEPTH) begin
                    part_block[b]         = rest;
                    part_block[part_size] = overlap;
                    part_size++;
                    split_tally++;
                end
            end
        end else if (w.block_index < part_size) begin
            r.block_mask = part_block[w.block_index];
        end else begin
            r.out_of_range = 1'b1;
        end
        r.block_count = COUNT_W'(part_size);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            for (int b = 0; b < STORE_DEPTH; b++) begin
                part_block[b] = '0;
            end
            part_block[0] = STATE_SPAN;
            part_size     = 1;
            awaited_rsp.delete();
            fail_tally    = 0;
            result_tally  = 0;
            split_tally   = 0;
        end else begin
            if (i_strobe) begin
                if (awaited_rsp.size() == 0) begin
                    $display("%0t: result word with none expected: count %0d mask %h oor %b",
                             $time, i_rsp.block_count, i_rsp.block_mask, i_rsp.out_of_range);
                    fail_tally++;
                end else begin
                    want = awaited_rsp.pop_front();
                    result_tally++;
                    if (i_rsp.block_count !== want.block_count) begin
                        $display("%0t: block_count mismatch, expected %0d, got %0d",
                                 $time, want.block_count, i_rsp.block_count);
                        fail_tally++;
                    end
                    if (i_rsp.block_mask !== want.block_mask) begin
                        $display("%0t: block_mask mismatch, expected %h, got %h",
                                 $time, want.block_mask, i_rsp.block_mask);
                        fail_tally++;
                    end
                    if (i_rsp.out_of_range !== want.out_of_range) begin
                        $display("%0t: out_of_range mismatch, expected %b, got %b",
                                 $time, want.out_of_range, i_rsp.out_of_range);
                        fail_tally++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                awaited_rsp.push_back(apply_word(i_req));
            end
        end
        o_fail_count   <= fail_tally;
        o_pending      <= awaited_rsp.size();
        o_result_count <= result_tally;
        o_split_count  <= split_tally;
    end

endmodule

// ===== tb/label_partition_refiner_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Label partition refiner testbench
// Drives a short directed sequence of refine and read words and then a long
// random one, mostly sparse labels so that the partition grows gradually,
// through phases with and without idle cycles on the request side. The
// checker beside the block predicts and compares; this module gives the
// verdict once every result word has arrived.
// ----------------------------------------------------------------------------
module label_partition_refiner_tb;
    import lpr_pkg::*;
    import lpr_tb_pkg::*;

    localparam int NUM_STATES   = NUM_STATES_DEF;
    localparam int RANDOM_WORDS = 930;
    localparam int DRAIN_CYCLES = 140;
    localparam int RUN_LIMIT    = 1_000_000;
    localparam int WIDE_LABELS  = 600;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    logic o_strobe;
    t_req i_req;
    t_rsp o_rsp;

    int fail_count;
    int pending;
    int result_count;
    int split_count;
    int idle_pct    = 0;
    int cycle_count = 0;
    int refine_sent = 0;
    int read_sent   = 0;
    int idle_tab [4] = '{0, 46, 10, 46};

    label_partition_refiner #(
        .NUM_STATES(NUM_STATES)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_req   (i_req),
        .busy    (busy),
        .o_rsp   (o_rsp),
        .o_strobe(o_strobe)
    );

    label_partition_refiner_checker #(
        .NUM_STATES(NUM_STATES)
    ) u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_req         (i_req),
        .i_rsp         (o_rsp),
        .i_strobe      (o_strobe),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_result_count(result_count),
        .o_split_count (split_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("label_partition_refiner test failed");
            $finish;
        end
    end

    function automatic logic [MASK_W-1:0] rand_mask();
        return {$urandom, $urandom};
    endfunction

    function automatic t_req make_word(input logic kind, input logic [MASK_W-1:0] mask,
                                       input int idx);
        t_req w;
        w.req_type    = kind;
        w.label_mask  = mask;
        w.block_index = ADDR_W'(idx);
        return w;
    endfunction

    // Refine labels are mostly sparse so that blocks split a few at a time;
    // dense random labels come only late in the run.
    function automatic t_req random_word(input int n);
        t_req w;
        int   pick;
        int   span;
        int   low;
        w.req_type    = ($urandom_range(99) < 55) ? REQ_READ : REQ_REFINE;
        w.block_index = ADDR_W'($urandom_range(STORE_DEPTH - 1));
        w.label_mask  = rand_mask();
        if (w.req_type == REQ_REFINE) begin
            pick = $urandom_range(99);
            if (pick < 30) begin
                w.label_mask = MASK_W'(1) << $urandom_range(MASK_W - 1);
            end else if (pick < 55) begin
                span         = $urandom_range(1, 8);
                low          = $urandom_range(0, MASK_W - span);
                w.label_mask = ((MASK_W'(1) << span) - 1) << low;
            end else if (pick < 65) begin
                w.label_mask = ($urandom_range(1) == 1) ? '1 : '0;
            end else if (pick < 85) begin
                w.label_mask = rand_mask() & rand_mask() & rand_mask();
            end else if (n < WIDE_LABELS) begin
                w.label_mask = ~(MASK_W'(1) << $urandom_range(MASK_W - 1));
            end
        end
        return w;
    endfunction

    // Presents one word, dropping start at random while idling, and returns
    // after the edge that accepts it. Start stays high for the next caller.
    task automatic send_word(input t_req w);
        bit present;
        i_req <= w;
        do begin
            present = ($urandom_range(99) >= idle_pct);
            start <= present;
            @(posedge i_clk);
        end while (!(present && !busy));
        if (w.req_type == REQ_REFINE) begin
            refine_sent++;
        end else begin
            read_sent++;
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_req   <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_word(make_word(REQ_READ, '0, 0));
        send_word(make_word(REQ_READ, '1, 1));
        send_word(make_word(REQ_READ, '0, STORE_DEPTH - 1));
        send_word(make_word(REQ_REFINE, '0, 0));
        send_word(make_word(REQ_REFINE, '1, STORE_DEPTH - 1));
        send_word(make_word(REQ_REFINE, 64'h8000_0000_0000_0000, 0));
        send_word(make_word(REQ_READ, '0, 0));
        send_word(make_word(REQ_READ, '0, 1));
        send_word(make_word(REQ_READ, '0, 2));
        send_word(make_word(REQ_REFINE, 64'h0000_0000_0000_0001, 0));
        send_word(make_word(REQ_REFINE, 64'h5555_5555_5555_5555, 0));
        send_word(make_word(REQ_READ, '0, 1));
        send_word(make_word(REQ_READ, '0, 3));
        send_word(make_word(REQ_REFINE, 64'hFFFF_FFFF_0000_0000, 0));
        send_word(make_word(REQ_REFINE, '1, 0));
        send_word(make_word(REQ_READ, '0, STORE_DEPTH - 1));
        send_word(make_word(REQ_REFINE, 64'hFFFF_0000_FFFF_0000, 0));
        send_word(make_word(REQ_READ, '0, 4));
        send_word(make_word(REQ_READ, '1, 0));

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            idle_pct = idle_tab[(n * 4) / RANDOM_WORDS];
            send_word(random_word(n));
        end
        start <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d refine and %0d read words; %0d result words checked.",
                 refine_sent, read_sent, result_count);
        $display("The partition went through %0d block splits.", split_count);
        if (pending != 0) begin
            $display("%0t: %0d result words never arrived", $time, pending);
        end
        if (fail_count == 0 && pending == 0) begin
            $display("label_partition_refiner test passed");
        end else begin
            $display("label_partition_refiner test failed");
        end
        $finish;
    end

endmodule
